// ===== sv/vfa_pkg.sv =====
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared constants, opcodes and queue entry type of the vector ALU.
// ----------------------------------------------------------------------------
package vfa_pkg;

  localparam int DW = 32;          // data word, two's complement
  localparam int FB = 16;          // fraction bits
  localparam int PW = 2 * DW;      // full product
  localparam int SW = PW + 2;      // sum of three products
  localparam int RW = DW;          // root bits of a sum of three squares
  localparam int NW = DW + FB;     // dividend |a| << FB

  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_SCALE     = 4'd2,
    OP_DIV       = 4'd3,
    OP_NEG       = 4'd4,
    OP_DOT       = 4'd5,
    OP_CROSS     = 4'd6,
    OP_NORM      = 4'd7,
    OP_NORMALIZE = 4'd8
  } op_e;

  // classified item as it sits in the queue
  typedef struct packed {
    logic [3:0]          opcode;
    logic                known;
    logic                s_zero;
    logic [2:0][DW-1:0]  a;
    logic [2:0][DW-1:0]  b;
    logic [DW-1:0]       s;
  } fe_t;

endpackage

// ===== sv/vfa_if.sv =====
// ----------------------------------------------------------------------------
// vfa_in_if / vfa_out_if
// Valid/ready channels of the vector ALU, operands in and results out.
// ----------------------------------------------------------------------------
interface vfa_in_if;
  logic                            valid;
  logic                            ready;
  logic [3:0]                      opcode;
  logic signed [vfa_pkg::DW-1:0]   a_x;
  logic signed [vfa_pkg::DW-1:0]   a_y;
  logic signed [vfa_pkg::DW-1:0]   a_z;
  logic signed [vfa_pkg::DW-1:0]   b_x;
  logic signed [vfa_pkg::DW-1:0]   b_y;
  logic signed [vfa_pkg::DW-1:0]   b_z;
  logic signed [vfa_pkg::DW-1:0]   scalar_in;

  modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  input ready);
  modport sink   (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  output ready);
endinterface

interface vfa_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [vfa_pkg::DW-1:0]   res_x;
  logic signed [vfa_pkg::DW-1:0]   res_y;
  logic signed [vfa_pkg::DW-1:0]   res_z;
  logic signed [vfa_pkg::DW-1:0]   res_scalar;
  logic                            overflow_flag;
  logic                            divide_error;

  modport source (output valid, res_x, res_y, res_z, res_scalar, overflow_flag,
                  divide_error, input ready);
  modport sink   (input valid, res_x, res_y, res_z, res_scalar, overflow_flag,
                  divide_error, output ready);
endinterface

// ===== sv/vfa_front.sv =====
// ----------------------------------------------------------------------------
// vfa_front
// Input register: takes a transaction, decodes the opcode, flags a zero divisor.
// ----------------------------------------------------------------------------
module vfa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  vfa_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output vfa_pkg::fe_t  ent_o
);
  import vfa_pkg::*;

  logic vld_q;
  fe_t  ent_q, ent_d;

  assign in_i.ready = !vld_q || !full_i;
  assign push_o     = vld_q && !full_i;
  assign ent_o      = ent_q;

  always_comb begin
    ent_d.opcode = in_i.opcode;
    ent_d.known  = (in_i.opcode <= OP_NORMALIZE);
    ent_d.s_zero = (in_i.scalar_in == '0);
    ent_d.a      = {in_i.a_z, in_i.a_y, in_i.a_x};
    ent_d.b      = {in_i.b_z, in_i.b_y, in_i.b_x};
    ent_d.s      = in_i.scalar_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ent_q <= ent_d;
    end
  end

endmodule

// ===== sv/vfa_fifo.sv =====
// ----------------------------------------------------------------------------
// vfa_fifo
// Short show-ahead queue between the front and the execution pipeline.
// ----------------------------------------------------------------------------
module vfa_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vfa_pkg::fe_t  din_i,
  output logic          full_o,
  input  logic          pop_i,
  output vfa_pkg::fe_t  dout_o,
  output logic          empty_o
);
  import vfa_pkg::*;

  fe_t              mem_q [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_q, rd_q;
  logic [FQ_CW-1:0] cnt_q;

  assign full_o  = (cnt_q == FQ_CW'(FQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

// ===== sv/vfa_back.sv =====
// ----------------------------------------------------------------------------
// vfa_back
// Execution pipeline: multiply, sum, saturate, square root, divide, output.
// ----------------------------------------------------------------------------
module vfa_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vfa_pkg::fe_t  hd_i,
  input  logic          empty_i,
  output logic          pop_o,
  vfa_out_if.source     out_o
);
  import vfa_pkg::*;

  typedef struct packed {
    logic [DW-1:0] v;
    logic          o;
  } sat_t;

  typedef struct packed {
    logic [3:0]          opcode;
    logic                derr;
    logic                ovf;
    logic [2:0][DW-1:0]  r;
    logic [DW-1:0]       rs;
    logic [2:0]          neg;
    logic [2:0][DW-1:0]  amag;
    logic [DW-1:0]       smag;
  } ctl_t;

  typedef struct packed {
    logic [PW-1:0] x;
    logic [DW:0]   rem;
    logic [RW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DW-1:0]          den;
    logic [2:0][NW-1:0]     nq;
    logic [2:0][DW-1:0]     rem;
  } dv_t;

  typedef struct packed {
    fe_t                 e;
    logic [5:0][PW-1:0]  p;
  } b1_t;

  typedef struct packed {
    fe_t                 e;
    logic [2:0][SW-1:0]  acc;
    logic [PW-1:0]       ssq;
  } b2_t;

  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [NW-1:0] QMAX = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};

  function automatic logic signed [SW-1:0] sx_w(input logic [DW-1:0] v);
    return {{(SW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] sx_p(input logic [PW-1:0] v);
    return {{(SW-PW){v[PW-1]}}, v};
  endfunction

  function automatic sat_t sat_sw(input logic [SW-1:0] v);
    logic [SW-DW:0] hi;
    sat_t           r;
    hi  = v[SW-1:DW-1];
    r.v = v[DW-1:0];
    r.o = 1'b0;
    if (!(&hi) && (|hi)) begin
      r.o = 1'b1;
      r.v = v[SW-1] ? DMIN : DMAX;
    end
    return r;
  endfunction

  function automatic sat_t rescale(input logic [SW-1:0] v);
    return sat_sw($signed(v) >>> FB);
  endfunction

  function automatic sat_t q_sat(input logic [NW-1:0] q, input logic neg);
    logic [NW-1:0] nq;
    sat_t          r;
    nq  = -q;
    r.o = 1'b0;
    if (neg) begin
      r.v = nq[DW-1:0];
      if (q > (QMAX + 1'b1)) begin
        r.o = 1'b1;
        r.v = DMIN;
      end
    end else begin
      r.v = q[DW-1:0];
      if (q > QMAX) begin
        r.o = 1'b1;
        r.v = DMAX;
      end
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? -v : v;
  endfunction

  // one root bit per stage
  function automatic sq_t sq_step(input sq_t s);
    logic [DW+1:0] rs, tr, df;
    sq_t           r;
    rs   = {s.rem[DW-1:0], s.x[PW-1:PW-2]};
    tr   = {s.root, 2'b01};
    df   = rs - tr;
    r.x  = s.x << 2;
    if (rs >= tr) begin
      r.rem  = df[DW:0];
      r.root = {s.root[RW-2:0], 1'b1};
    end else begin
      r.rem  = rs[DW:0];
      r.root = {s.root[RW-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit per stage, three lanes
  function automatic dv_t dv_step(input dv_t s);
    logic [DW:0] rs, df;
    dv_t         r;
    r.den = s.den;
    for (int i = 0; i < 3; i++) begin
      rs = {s.rem[i], s.nq[i][NW-1]};
      df = rs - {1'b0, s.den};
      if (rs >= {1'b0, s.den}) begin
        r.rem[i] = df[DW-1:0];
        r.nq[i]  = {s.nq[i][NW-2:0], 1'b1};
      end else begin
        r.rem[i] = rs[DW-1:0];
        r.nq[i]  = {s.nq[i][NW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic         adv;
  logic         b1_vld_q, b2_vld_q, out_vld_q;
  logic [RW:0]  sq_vld_q;
  logic [NW:0]  dv_vld_q;
  b1_t          b1_q, b1_d;
  b2_t          b2_q, b2_d;
  ctl_t         sq_ctl_q [RW+1];
  sq_t          sq_q     [RW+1];
  ctl_t         dv_ctl_q [NW+1];
  dv_t          dv_q     [NW+1];
  ctl_t         b3_ctl, dv0_ctl, fin_ctl, out_q;
  sq_t          b3_sq;
  dv_t          dv0;

  assign adv   = !out_vld_q || out_o.ready;
  assign pop_o = adv && !empty_i;

  // stage 1: six multipliers, operands picked by opcode
  always_comb begin
    logic [5:0][DW-1:0] opa, opb;
    fe_t e;
    e   = hd_i;
    opa = {e.a[1], e.a[0], e.a[0], e.a[2], e.a[2], e.a[1]};
    opb = {e.b[0], e.b[1], e.b[2], e.b[0], e.b[1], e.b[2]};
    unique case (e.opcode)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opa[2*i] = e.a[i];
          opb[2*i] = e.s;
        end
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opa[2*i] = e.a[i];
          opb[2*i] = e.b[i];
        end
      end
      OP_NORM, OP_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          opa[2*i] = e.a[i];
          opb[2*i] = e.a[i];
        end
      end
      default: ;
    endcase
    b1_d.e = e;
    for (int k = 0; k < 6; k++) begin
      b1_d.p[k] = $signed(opa[k]) * $signed(opb[k]);
    end
  end

  // stage 2: sums and differences at full precision
  always_comb begin
    b2_d.e   = b1_q.e;
    b2_d.ssq = b1_q.p[0] + b1_q.p[2] + b1_q.p[4];
    for (int i = 0; i < 3; i++) begin
      b2_d.acc[i] = sx_p(b1_q.p[2*i]);
    end
    unique case (b1_q.e.opcode)
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          b2_d.acc[i] = sx_p(b1_q.p[2*i]) - sx_p(b1_q.p[2*i+1]);
        end
      end
      OP_DOT: begin
        b2_d.acc[0] = sx_p(b1_q.p[0]) + sx_p(b1_q.p[2]) + sx_p(b1_q.p[4]);
      end
      default: ;
    endcase
  end

  // stage 3: element-wise results, saturation, root setup
  always_comb begin
    sat_t sr;
    fe_t  e;
    e      = b2_q.e;
    b3_ctl = '0;
    sr     = '0;
    b3_ctl.opcode = e.opcode;
    b3_ctl.smag   = mag(e.s);
    for (int i = 0; i < 3; i++) begin
      b3_ctl.amag[i] = mag(e.a[i]);
      b3_ctl.neg[i]  = e.a[i][DW-1];
    end
    if (e.known) begin
      unique case (op_e'(e.opcode))
        OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CROSS: begin
          for (int i = 0; i < 3; i++) begin
            if (e.opcode == OP_ADD)      sr = sat_sw(sx_w(e.a[i]) + sx_w(e.b[i]));
            else if (e.opcode == OP_SUB) sr = sat_sw(sx_w(e.a[i]) - sx_w(e.b[i]));
            else if (e.opcode == OP_NEG) sr = sat_sw(SW'(0) - sx_w(e.a[i]));
            else                         sr = rescale(b2_q.acc[i]);
            b3_ctl.r[i] = sr.v;
            b3_ctl.ovf  = b3_ctl.ovf | sr.o;
          end
        end
        OP_DOT: begin
          sr          = rescale(b2_q.acc[0]);
          b3_ctl.rs   = sr.v;
          b3_ctl.ovf  = sr.o;
        end
        OP_DIV: begin
          b3_ctl.derr = e.s_zero;
          for (int i = 0; i < 3; i++) begin
            b3_ctl.neg[i] = e.a[i][DW-1] ^ e.s[DW-1];
          end
        end
        OP_NORM, OP_NORMALIZE: ;
        default: ;
      endcase
    end
    b3_sq.x    = b2_q.ssq;
    b3_sq.rem  = '0;
    b3_sq.root = '0;
  end

  // divider entry: norm result, divisor select
  always_comb begin
    logic [RW-1:0] root;
    dv0_ctl = sq_ctl_q[RW];
    root    = sq_q[RW].root;
    if (dv0_ctl.opcode == OP_NORM) begin
      dv0_ctl.rs  = root[DW-1] ? DMAX : root;
      dv0_ctl.ovf = root[DW-1];
    end
    if (dv0_ctl.opcode == OP_NORMALIZE) begin
      dv0_ctl.derr = (root == '0);
    end
    dv0.den = (dv0_ctl.opcode == OP_DIV) ? dv0_ctl.smag : root;
    for (int i = 0; i < 3; i++) begin
      dv0.nq[i]  = {dv0_ctl.amag[i], {FB{1'b0}}};
      dv0.rem[i] = '0;
    end
  end

  // final: quotients into the vector result
  always_comb begin
    sat_t qs;
    fin_ctl = dv_ctl_q[NW];
    qs      = '0;
    if ((fin_ctl.opcode == OP_DIV || fin_ctl.opcode == OP_NORMALIZE) && !fin_ctl.derr) begin
      for (int i = 0; i < 3; i++) begin
        qs             = q_sat(dv_q[NW].nq[i], fin_ctl.neg[i]);
        fin_ctl.r[i]   = qs.v;
        fin_ctl.ovf    = fin_ctl.ovf | qs.o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      b1_vld_q  <= pop_o;
      b2_vld_q  <= b1_vld_q;
      sq_vld_q  <= {sq_vld_q[RW-1:0], b2_vld_q};
      dv_vld_q  <= {dv_vld_q[NW-1:0], sq_vld_q[RW]};
      out_vld_q <= dv_vld_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_q        <= b1_d;
      b2_q        <= b2_d;
      sq_ctl_q[0] <= b3_ctl;
      sq_q[0]     <= b3_sq;
      for (int k = 0; k < RW; k++) begin
        sq_ctl_q[k+1] <= sq_ctl_q[k];
        sq_q[k+1]     <= sq_step(sq_q[k]);
      end
      dv_ctl_q[0] <= dv0_ctl;
      dv_q[0]     <= dv0;
      for (int k = 0; k < NW; k++) begin
        dv_ctl_q[k+1] <= dv_ctl_q[k];
        dv_q[k+1]     <= dv_step(dv_q[k]);
      end
      out_q <= fin_ctl;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.res_x         = out_q.r[0];
  assign out_o.res_y         = out_q.r[1];
  assign out_o.res_z         = out_q.r[2];
  assign out_o.res_scalar    = out_q.rs;
  assign out_o.overflow_flag = out_q.ovf;
  assign out_o.divide_error  = out_q.derr;

endmodule

// ===== sv/vector3_fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu
// Three-component Q16.16 vector unit: add, sub, scale, divide, negate, dot,
// cross, norm and normalize with saturation and divide-error flags.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out, in order. The unit takes a
// new transaction every cycle and returns one every cycle while the output
// side keeps ready high. Each transaction passes through the input register,
// queue, multiply, sum, saturate, DW square-root stages (one root bit each,
// DW = 32 for Q16.16), a divider entry register and DW+FB restoring divider
// stages (one quotient bit each, three lanes), then the output register.
// Norm and normalize need the root before the divide, so both chains sit in
// series. A low ready on the output while a result is held freezes the whole
// execution pipeline; the two-entry queue and the input register keep
// taking transactions until they fill. Overflowing results saturate and set
// overflow_flag; divide by zero or normalizing a zero vector returns zeros
// with divide_error set. Opcodes 9 to 15 return all zeros.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu (
  input  logic       clk_i,
  input  logic       rst_ni,
  vfa_in_if.sink     in_i,
  vfa_out_if.source  out_o
);
  import vfa_pkg::*;

  // front to queue
  logic push, full;
  fe_t  fe_ent;

  // queue to execution
  logic pop, empty;
  fe_t  hd;

  vfa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .ent_o  (fe_ent)
  );

  vfa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (fe_ent),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (hd),
    .empty_o (empty)
  );

  vfa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hd_i    (hd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // a divide error never comes with saturation and always zeroes the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.divide_error |->
      !out_o.overflow_flag && out_o.res_x == '0 && out_o.res_y == '0 &&
      out_o.res_z == '0 && out_o.res_scalar == '0)
    else $error("divide error with nonzero result");

  // scalar results (dot, norm) leave the vector part zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.res_scalar != '0 |->
      out_o.res_x == '0 && out_o.res_y == '0 && out_o.res_z == '0)
    else $error("scalar and vector result both set");

endmodule
